/* hdl/bcc_pkg.sv */
// Shared constants, types and arithmetic helpers of the band clearance checker.
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  // Number of horizontal bands when the top level is not told otherwise.
  localparam int unsigned BAND_COUNT_DEF = 4;

  // Field and register widths.
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned PERMILLE_W = 10;
  localparam int unsigned CLEAR_W    = 3;
  localparam int unsigned DARK_W     = 24;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PROD_W     = 2 * DIM_W;
  localparam int unsigned CMP_W      = 34;

  // Dark count saturation value and the per-mille scale of the band test.
  localparam logic [DARK_W-1:0]     DARK_MAX    = '1;
  localparam logic [PERMILLE_W-1:0] PERMILLE_ONE = 10'd1000;

  // Register values after reset.
  localparam logic [DIM_W-1:0]      RST_FRAME_WIDTH   = 12'd640;
  localparam logic [DIM_W-1:0]      RST_FRAME_HEIGHT  = 12'd480;
  localparam logic [PIX_W-1:0]      RST_DARK_LEVEL    = 8'd60;
  localparam logic [PERMILLE_W-1:0] RST_DARK_PERMILLE = 10'd50;

  // Register map, one 32-bit word per register.
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_DARK_LEVEL    = 2'd2,
    REG_DARK_PERMILLE = 2'd3
  } reg_idx_e;

  // Live configuration as the pixel datapath sees it.
  typedef struct packed {
    logic [DIM_W-1:0]      frame_width;
    logic [DIM_W-1:0]      frame_height;
    logic [PIX_W-1:0]      dark_level;
    logic [PERMILLE_W-1:0] dark_permille;
    logic [DIM_W-1:0]      band_rows;
  } cfg_t;

  // Kinds of event that one pixel can hand to the verdict pipeline.
  typedef struct packed {
    logic frame_begin;
    logic verdict;
    logic result;
  } ev_ctl_t;

  // Operands of a band verdict.
  typedef struct packed {
    logic [DARK_W-1:0]     dark;
    logic [DIM_W-1:0]      win_width;
    logic [DIM_W-1:0]      band_rows;
    logic [PERMILLE_W-1:0] permille;
  } ev_data_t;

  // One result item.
  typedef struct packed {
    logic               go_forward;
    logic [CLEAR_W-1:0] clear_bands;
  } res_t;

  // floor(x / 10) by reciprocal multiplication, exact for every 12-bit x.
  function automatic logic [DIM_W-1:0] div_by_ten(input logic [DIM_W-1:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd52429;
    return {3'b000, p[27:19]};
  endfunction

  // floor(w * 4 / 5), exact for every 12-bit w; the result fits in 12 bits.
  function automatic logic [DIM_W-1:0] shrink_width(input logic [DIM_W-1:0] w);
    logic [29:0] p;
    p = 30'({w, 2'b00}) * 30'd52429;
    return p[29:18];
  endfunction

endpackage

`default_nettype wire

/* hdl/band_clearance_checker.sv */
// Top level of the band clearance checker: pixel datapath and block wiring.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_ready_o  pixel_i, frame_start_i
//   out      output     out_valid_o / out_ready_i go_forward_o, clear_bands_o
//   config   input      APB psel/penable/pready  paddr, pwdata, prdata
//
// One pixel is taken every cycle while in_ready_o is high; its position,
// window test and dark count are settled in the cycle after it is registered.
// A frame result passes the input register, the event register and the
// two-stage verdict multiply pipeline before it enters the result buffer.
// in_ready_o falls only while two results wait and a third reaches the tail.
// Reset clears the position, the dark count, the flags and the buffer.
`timescale 1ns / 1ps
`default_nettype none

module band_clearance_checker #(
  parameter int unsigned BAND_COUNT = bcc_pkg::BAND_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bcc_pkg::PIX_W-1:0]         pixel_i,
  input  logic                              frame_start_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              go_forward_o,
  output logic [bcc_pkg::CLEAR_W-1:0]       clear_bands_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bcc_pkg::ADDR_W-1:0]        paddr,
  input  logic [bcc_pkg::DATA_W-1:0]        pwdata,
  output logic [bcc_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  localparam int unsigned DIM_W  = bcc_pkg::DIM_W;
  localparam int unsigned DARK_W = bcc_pkg::DARK_W;
  localparam int unsigned KW     = $clog2(BAND_COUNT);

  bcc_pkg::cfg_t                  cfg;
  logic [DIM_W-1:0]               win_left_cfg  [BAND_COUNT];
  logic [DIM_W-1:0]               win_width_cfg [BAND_COUNT];
  logic [DIM_W-1:0]               band_end      [BAND_COUNT];
  logic [DIM_W-1:0]               win_left_q    [BAND_COUNT];
  logic [DIM_W-1:0]               win_width_q   [BAND_COUNT];
  logic                           advance;
  logic                           step;
  logic                           s0_valid_q;
  logic [bcc_pkg::PIX_W-1:0]      s0_pixel_q;
  logic                           s0_start_q;
  logic [DIM_W-1:0]               col_q;
  logic [DIM_W-1:0]               row_q;
  logic [DARK_W-1:0]              dark_q;
  logic [DIM_W-1:0]               col_cur;
  logic [DIM_W-1:0]               row_cur;
  logic [DIM_W-1:0]               col_d;
  logic [DIM_W-1:0]               row_d;
  logic [DARK_W-1:0]              dark_d;
  logic [DARK_W-1:0]              dark_base;
  logic [DARK_W-1:0]              dark_new;
  logic [DIM_W-1:0]               last_col;
  logic [DIM_W-1:0]               last_row;
  logic [DIM_W:0]                 row_next;
  logic [DIM_W-1:0]               left_sel;
  logic [DIM_W-1:0]               width_sel;
  logic [KW-1:0]                  band_sel;
  logic                           frame_begin;
  logic                           end_col;
  logic                           end_row;
  logic                           in_bands;
  logic                           band_end_row;
  logic                           in_window;
  logic                           dark_inc;
  logic                           band_done;
  logic                           frame_done;
  logic                           ev_valid_q;
  bcc_pkg::ev_ctl_t               ev_ctl_q;
  logic [KW-1:0]                  ev_band_q;
  bcc_pkg::ev_data_t              ev_data_q;
  bcc_pkg::res_t                  out_res;

  bcc_regs #(
    .BAND_COUNT (BAND_COUNT)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .win_left_o  (win_left_cfg),
    .win_width_o (win_width_cfg),
    .band_end_o  (band_end)
  );

  // Input register.
  assign in_ready_o = advance;
  assign step       = advance && s0_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (advance) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s0_pixel_q <= pixel_i;
      s0_start_q <= frame_start_i;
    end
  end

  // Position of the pixel and the end of its row and frame.
  always_comb begin
    col_cur     = s0_start_q ? '0 : col_q;
    row_cur     = s0_start_q ? '0 : row_q;
    frame_begin = (col_cur == '0) && (row_cur == '0);
    last_col    = (cfg.frame_width == '0) ? '0 : cfg.frame_width - 1'b1;
    last_row    = (cfg.frame_height == '0) ? '0 : cfg.frame_height - 1'b1;
    end_col     = col_cur >= last_col;
    end_row     = row_cur >= last_row;
    frame_done  = end_col && end_row;
  end

  // Band lookup by comparing the row against each band boundary.
  always_comb begin
    in_bands     = (cfg.band_rows != '0) && (row_cur < band_end[BAND_COUNT-1]);
    row_next     = {1'b0, row_cur} + 1'b1;
    band_sel     = KW'(BAND_COUNT - 1);
    band_end_row = 1'b0;
    for (int j = 0; j < BAND_COUNT; j++) begin
      if (j < BAND_COUNT - 1 && row_cur >= band_end[j]) begin
        band_sel = KW'(BAND_COUNT - 2 - j);
      end
      if (row_next == {1'b0, band_end[j]}) begin
        band_end_row = 1'b1;
      end
    end
  end

  // Window test and dark count; the first pixel of a frame uses fresh windows.
  always_comb begin
    left_sel  = frame_begin ? win_left_cfg[band_sel]  : win_left_q[band_sel];
    width_sel = frame_begin ? win_width_cfg[band_sel] : win_width_q[band_sel];
    in_window = ({1'b0, col_cur} >= {1'b0, left_sel}) &&
                ({1'b0, col_cur} < ({1'b0, left_sel} + {1'b0, width_sel}));
    dark_base = frame_begin ? '0 : dark_q;
    dark_inc  = in_bands && in_window && (s0_pixel_q < cfg.dark_level) &&
                (dark_base != bcc_pkg::DARK_MAX);
    dark_new  = dark_base + DARK_W'(dark_inc);
    band_done = in_bands && end_col && band_end_row;
    dark_d    = band_done ? '0 : dark_new;
  end

  // Next position.
  always_comb begin
    col_d = end_col ? '0 : col_cur + 1'b1;
    row_d = row_cur;
    if (end_col) begin
      row_d = end_row ? '0 : row_cur + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      dark_q <= '0;
    end else if (step) begin
      col_q  <= col_d;
      row_q  <= row_d;
      dark_q <= dark_d;
    end
  end

  // Windows are frozen at the start of each frame.
  always_ff @(posedge clk_i) begin
    if (step && frame_begin) begin
      win_left_q  <= win_left_cfg;
      win_width_q <= win_width_cfg;
    end
  end

  // Event register feeding the verdict pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (advance) begin
      ev_valid_q <= step && (frame_begin || band_done || frame_done);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ev_ctl_q.frame_begin <= frame_begin;
      ev_ctl_q.verdict     <= band_done;
      ev_ctl_q.result      <= frame_done;
      ev_band_q            <= band_sel;
      ev_data_q.dark       <= dark_new;
      ev_data_q.win_width  <= width_sel;
      ev_data_q.band_rows  <= cfg.band_rows;
      ev_data_q.permille   <= cfg.dark_permille;
    end
  end

  bcc_judge #(
    .BAND_COUNT (BAND_COUNT)
  ) u_judge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (ev_valid_q),
    .ev_ctl_i    (ev_ctl_q),
    .ev_band_i   (ev_band_q),
    .ev_data_i   (ev_data_q),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  assign go_forward_o  = out_res.go_forward;
  assign clear_bands_o = out_res.clear_bands;

endmodule

`default_nettype wire

/* hdl/bcc_regs.sv */
// Configuration registers, APB access and the band geometry derived from them.
`timescale 1ns / 1ps
`default_nettype none

module bcc_regs #(
  parameter int unsigned BAND_COUNT = bcc_pkg::BAND_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bcc_pkg::ADDR_W-1:0]          paddr,
  input  logic [bcc_pkg::DATA_W-1:0]          pwdata,
  output logic [bcc_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  output bcc_pkg::cfg_t                       cfg_o,
  output logic [bcc_pkg::DIM_W-1:0]           win_left_o  [BAND_COUNT],
  output logic [bcc_pkg::DIM_W-1:0]           win_width_o [BAND_COUNT],
  output logic [bcc_pkg::DIM_W-1:0]           band_end_o  [BAND_COUNT]
);

  localparam int unsigned DIM_W = bcc_pkg::DIM_W;
  // Reciprocal of the band count, rounded up, scaled by 2^20.
  localparam logic [19:0] BR_RECIP = 20'(((1 << 20) + BAND_COUNT - 1) / BAND_COUNT);

  bcc_pkg::reg_idx_e                  reg_idx;
  logic                               wr_en;
  logic [DIM_W-1:0]                   frame_width_q;
  logic [DIM_W-1:0]                   frame_height_q;
  logic [bcc_pkg::PIX_W-1:0]          dark_level_q;
  logic [bcc_pkg::PERMILLE_W-1:0]     dark_permille_q;
  logic [DIM_W-1:0]                   width_src;
  logic [DIM_W-1:0]                   height_src;
  logic [31:0]                        rows_prod;
  logic [DIM_W-1:0]                   band_rows_d;
  logic [DIM_W-1:0]                   band_rows_q;
  logic [DIM_W-1:0]                   win_left_d  [BAND_COUNT];
  logic [DIM_W-1:0]                   win_width_d [BAND_COUNT];
  logic [DIM_W-1:0]                   win_left_q  [BAND_COUNT];
  logic [DIM_W-1:0]                   win_width_q [BAND_COUNT];

  assign reg_idx = bcc_pkg::reg_idx_e'(paddr[bcc_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= bcc_pkg::RST_FRAME_WIDTH;
      frame_height_q  <= bcc_pkg::RST_FRAME_HEIGHT;
      dark_level_q    <= bcc_pkg::RST_DARK_LEVEL;
      dark_permille_q <= bcc_pkg::RST_DARK_PERMILLE;
    end else if (wr_en) begin
      case (reg_idx)
        bcc_pkg::REG_FRAME_WIDTH:   frame_width_q   <= pwdata[DIM_W-1:0];
        bcc_pkg::REG_FRAME_HEIGHT:  frame_height_q  <= pwdata[DIM_W-1:0];
        bcc_pkg::REG_DARK_LEVEL:    dark_level_q    <= pwdata[bcc_pkg::PIX_W-1:0];
        bcc_pkg::REG_DARK_PERMILLE: dark_permille_q <= pwdata[bcc_pkg::PERMILLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      bcc_pkg::REG_FRAME_WIDTH:   prdata = 32'(frame_width_q);
      bcc_pkg::REG_FRAME_HEIGHT:  prdata = 32'(frame_height_q);
      bcc_pkg::REG_DARK_LEVEL:    prdata = 32'(dark_level_q);
      bcc_pkg::REG_DARK_PERMILLE: prdata = 32'(dark_permille_q);
      default:                    prdata = '0;
    endcase
  end

  // The geometry follows the value being written so that it is current on
  // the same edge as the register itself.
  assign width_src  = (wr_en && reg_idx == bcc_pkg::REG_FRAME_WIDTH) ?
                      pwdata[DIM_W-1:0] : frame_width_q;
  assign height_src = (wr_en && reg_idx == bcc_pkg::REG_FRAME_HEIGHT) ?
                      pwdata[DIM_W-1:0] : frame_height_q;

  // Rows per band: the rounded-up reciprocal is exact for 12-bit heights.
  assign rows_prod   = 32'(height_src) * 32'(BR_RECIP);
  assign band_rows_d = rows_prod[31:20];

  // Band windows: each band above the bottom one shrinks toward the center.
  always_comb begin
    win_left_d[0]  = '0;
    win_width_d[0] = width_src;
    for (int k = 1; k < BAND_COUNT; k++) begin
      win_left_d[k]  = win_left_d[k-1] + bcc_pkg::div_by_ten(win_width_d[k-1]);
      win_width_d[k] = bcc_pkg::shrink_width(win_width_d[k-1]);
    end
  end

  // Derived values reload every cycle from the registers.
  always_ff @(posedge clk_i) begin
    band_rows_q <= band_rows_d;
    win_left_q  <= win_left_d;
    win_width_q <= win_width_d;
  end

  // First row past the end of each band, counted from the top of the frame.
  always_comb begin
    for (int j = 0; j < BAND_COUNT; j++) begin
      band_end_o[j] = DIM_W'(band_rows_q * (j + 1));
    end
  end

  assign win_left_o  = win_left_q;
  assign win_width_o = win_width_q;

  assign cfg_o.frame_width   = frame_width_q;
  assign cfg_o.frame_height  = frame_height_q;
  assign cfg_o.dark_level    = dark_level_q;
  assign cfg_o.dark_permille = dark_permille_q;
  assign cfg_o.band_rows     = band_rows_q;

endmodule

`default_nettype wire

/* hdl/bcc_judge.sv */
// Band verdict pipeline, clear flags and the result buffer.
`timescale 1ns / 1ps
`default_nettype none

module bcc_judge #(
  parameter int unsigned BAND_COUNT = bcc_pkg::BAND_COUNT_DEF,
  localparam int unsigned KW = $clog2(BAND_COUNT),
  localparam int unsigned CW = $clog2(BAND_COUNT + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            ev_valid_i,
  input  bcc_pkg::ev_ctl_t                ev_ctl_i,
  input  logic [KW-1:0]                   ev_band_i,
  input  bcc_pkg::ev_data_t               ev_data_i,
  output logic                            advance_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output bcc_pkg::res_t                   out_res_o
);

  localparam int unsigned PROD_W = bcc_pkg::PROD_W;
  localparam int unsigned CMP_W  = bcc_pkg::CMP_W;

  logic                               mp_valid_q;
  bcc_pkg::ev_ctl_t                   mp_ctl_q;
  logic [KW-1:0]                      mp_band_q;
  logic [PROD_W-1:0]                  mp_prod_q;
  logic [CMP_W-1:0]                   mp_lhs_q;
  logic [bcc_pkg::PERMILLE_W-1:0]     mp_permille_q;
  logic                               cp_valid_q;
  bcc_pkg::ev_ctl_t                   cp_ctl_q;
  logic [KW-1:0]                      cp_band_q;
  logic [CMP_W-1:0]                   cp_lhs_q;
  logic [CMP_W-1:0]                   cp_rhs_q;
  logic [BAND_COUNT-1:0]              flags_q;
  logic [BAND_COUNT-1:0]              flags_d;
  logic [CW-1:0]                      clear_cnt;
  logic                               run;
  bcc_pkg::res_t                      res_d;
  bcc_pkg::res_t                      buf_q [2];
  logic                               wr_ptr_q;
  logic                               rd_ptr_q;
  logic [1:0]                         cnt_q;
  logic                               push;
  logic                               pop;

  // The whole pipeline holds only when a result meets a full buffer.
  assign advance_o = !(cp_valid_q && cp_ctl_q.result && cnt_q == 2'd2);
  assign push      = advance_o && cp_valid_q && cp_ctl_q.result;
  assign pop       = out_valid_o && out_ready_i;

  // Stage one: band rows times window width, and the scaled dark count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_valid_q <= 1'b0;
      cp_valid_q <= 1'b0;
    end else if (advance_o) begin
      mp_valid_q <= ev_valid_i;
      cp_valid_q <= mp_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      mp_ctl_q      <= ev_ctl_i;
      mp_band_q     <= ev_band_i;
      mp_prod_q     <= PROD_W'(ev_data_i.band_rows) * PROD_W'(ev_data_i.win_width);
      mp_lhs_q      <= CMP_W'(ev_data_i.dark) * CMP_W'(bcc_pkg::PERMILLE_ONE);
      mp_permille_q <= ev_data_i.permille;
    end
  end

  // Stage two: the allowed dark budget of the band.
  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      cp_ctl_q  <= mp_ctl_q;
      cp_band_q <= mp_band_q;
      cp_lhs_q  <= mp_lhs_q;
      cp_rhs_q  <= CMP_W'(mp_prod_q) * CMP_W'(mp_permille_q);
    end
  end

  // Tail: a frame start clears the flags, a finished band sets its verdict,
  // and the end of a frame counts clear bands from the bottom up.
  always_comb begin
    flags_d = cp_ctl_q.frame_begin ? '0 : flags_q;
    if (cp_ctl_q.verdict) begin
      flags_d[cp_band_q] = cp_lhs_q < cp_rhs_q;
    end
    clear_cnt = '0;
    run       = 1'b1;
    for (int k = 0; k < BAND_COUNT; k++) begin
      if (run && flags_d[k]) begin
        clear_cnt = clear_cnt + 1'b1;
      end else begin
        run = 1'b0;
      end
    end
    res_d.go_forward  = (32'(clear_cnt) << 1) >= 32'(BAND_COUNT);
    res_d.clear_bands = bcc_pkg::CLEAR_W'(clear_cnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (advance_o && cp_valid_q) begin
      flags_q <= flags_d;
    end
  end

  // Two-entry result buffer decouples the output from the pixel stream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= res_d;
    end
  end

  assign out_valid_o = cnt_q != 2'd0;
  assign out_res_o   = buf_q[rd_ptr_q];

endmodule

`default_nettype wire

/* hdl/bcc_checker.sv */
// Port-level assertions of the band clearance checker and their bind.
`timescale 1ns / 1ps
`default_nettype none

module bcc_checker #(
  parameter int unsigned BAND_COUNT = bcc_pkg::BAND_COUNT_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          go_forward_o,
  input logic [bcc_pkg::CLEAR_W-1:0]   clear_bands_o
);

  // A waiting result item stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped before it was taken");

  // A waiting result item keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(go_forward_o) && $stable(clear_bands_o))
    else $error("result item changed while stalled");

  // The input side stalls only behind a result that waits.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // A full result buffer needs a refused result on the edge before.
  a_stall_past: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled without earlier output backpressure");

  // The go decision agrees with the reported count of clear bands.
  a_go_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (go_forward_o == ((32'(clear_bands_o) << 1) >= 32'(BAND_COUNT))) ||
                    (BAND_COUNT == 8 && clear_bands_o == '0 && go_forward_o))
    else $error("go_forward does not match clear_bands");

endmodule

bind band_clearance_checker bcc_checker #(
  .BAND_COUNT (BAND_COUNT)
) u_bcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .go_forward_o  (go_forward_o),
  .clear_bands_o (clear_bands_o)
);

`default_nettype wire
